// ===== design/fuzzy_subsequence_scorer_macros.svh =====
// assertion helpers
`ifndef FUZZY_SUBSEQUENCE_SCORER_MACROS_SVH
`define FUZZY_SUBSEQUENCE_SCORER_MACROS_SVH

// same-cycle implication
`define FSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define FSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/fss_pkg.sv =====
package fss_pkg;

  localparam int MAX_QUERY_DEF = 32;
  localparam int MAX_TEXT_DEF  = 256;

  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 17;
  localparam int NUM_W   = 48;

  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [31:0] DATE_BONUS = 32'h0002_0000;
  localparam logic [31:0] AGE_HOUR  = 32'd3600;
  localparam logic [31:0] AGE_DAY   = 32'd86400;
  localparam logic [31:0] AGE_WEEK  = 32'd604800;
  localparam logic [31:0] BONUS_HOUR = 32'd32768;
  localparam logic [31:0] BONUS_DAY  = 32'd19661;
  localparam logic [31:0] BONUS_WEEK = 32'd6554;

  localparam logic [7:0] CHAR_DASH = 8'd45;

  localparam logic [2:0] REG_CHARS_LOW  = 3'd0;
  localparam logic [2:0] REG_CHARS_MID  = 3'd1;
  localparam logic [2:0] REG_CHARS_HIGH = 3'd2;
  localparam logic [2:0] REG_CHARS_TOP  = 3'd3;
  localparam logic [2:0] REG_QLEN       = 3'd4;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== design/fss_if.sv =====
interface fss_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  text_char;
  logic        last;
  logic [31:0] age_seconds;
  modport source (output valid, text_char, last, age_seconds, input ready);
  modport sink (input valid, text_char, last, age_seconds, output ready);
endinterface

interface fss_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] score;
  logic        all_matched;
  modport source (output valid, score, all_matched, input ready);
  modport sink (input valid, score, all_matched, output ready);
endinterface

// ===== design/fss_div.sv =====
module fss_div
  import fss_pkg::*;
#(
  parameter int DW = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DW:0]      trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[NUM_W-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DW'(trial - {1'b0, den_q});
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== design/fuzzy_subsequence_scorer.sv =====
// a byte with no proximity term leaves the sequencer idle; when the gap is
// one the term is added directly, else the shared multiplier runs the 16-bit
// inverse sqrt search; a last byte adds three multiplies and a 48-step divide
// one byte in flight at a time; ready is low while the sequencer works
// reset (async, active low) clears the query registers and all text state
`include "fuzzy_subsequence_scorer_macros.svh"

module fuzzy_subsequence_scorer
  import fss_pkg::*;
#(
  parameter int MAX_QUERY = MAX_QUERY_DEF,
  parameter int MAX_TEXT  = MAX_TEXT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fss_in_if.sink      in_i,
  fss_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam int CW = $clog2(MAX_TEXT + 1);
  localparam int DW = 2 * CW + 2;
  localparam int PW = MUL_A_W + MUL_B_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PSQ  = 4'd1;
  localparam logic [3:0] S_PMUL = 4'd2;
  localparam logic [3:0] S_FIN  = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_AGE  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [255:0] qchars_q;
  logic [5:0]   qlen_q;
  logic [5:0]   qlen_eff;
  logic [7:0]   qbyte;

  logic [3:0]    state_q, state_d;
  logic [5:0]    qpos_q, qpos_d;
  logic [CW-1:0] lmp_q, lmp_d;
  logic          have_q, have_d;
  logic [CW-1:0] cc_q, cc_d;
  logic [7:0]    prev_q, prev_d;
  logic          date_q, date_d;
  logic [31:0]   run_q, run_d;
  logic [31:0]   age_q, age_d;
  logic          last_q, last_d;
  logic [CW-1:0] gap_q, gap_d;
  logic [15:0]   r_q, r_d;
  logic [3:0]    bit_q, bit_d;
  logic [33:0]   sq_q, sq_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [31:0]   score_q, score_d;
  logic          match_q, match_d;
  logic          ovalid_q, ovalid_d;
  logic [31:0]   oscore_q, oscore_d;
  logic          omatch_q, omatch_d;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PW-1:0]      prod;
  logic [15:0]        cand;
  logic [16:0]        tval;
  logic               active, hit, date_bad, boundary;
  logic               in_acc, div_start, div_done;
  logic [NUM_W-1:0]   quo;
  logic [31:0]        sfin;

  assign qlen_eff = (qlen_q > 6'(MAX_QUERY)) ? 6'(MAX_QUERY) : qlen_q;
  assign qbyte    = qchars_q[{qpos_q[4:0], 3'b000} +: 8];
  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign active   = cc_q < CW'(MAX_TEXT);
  assign hit      = active && (qpos_q < qlen_eff)
                    && (to_lower(in_i.text_char) == to_lower(qbyte));
  assign boundary = (cc_q == '0) || !is_alnum(prev_q);
  assign date_bad = active && (cc_q < CW'(11)) &&
                    (((cc_q == CW'(4)) || (cc_q == CW'(7)) || (cc_q == CW'(10)))
                     ? (in_i.text_char != CHAR_DASH) : !is_digit(in_i.text_char));

  assign cand = r_q | (16'h0001 << bit_q);
  assign tval = {cand, 1'b0} - 17'd1;
  assign sfin = (date_q && cc_q >= CW'(11)) ? sat_add(run_q, DATE_BONUS) : run_q;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_PSQ: begin
        mul_a = MUL_A_W'(tval);
        mul_b = tval;
      end
      S_PMUL: begin
        mul_a = MUL_A_W'(sq_q);
        mul_b = MUL_B_W'(gap_q);
      end
      S_M1: begin
        mul_a = MUL_A_W'(score_q);
        mul_b = MUL_B_W'(qlen_eff);
      end
      S_M2: begin
        mul_a = num_q;
        mul_b = MUL_B_W'(10);
      end
      S_M3: begin
        mul_a = MUL_A_W'(lmp_q) + MUL_A_W'(1);
        mul_b = MUL_B_W'(cc_q) + MUL_B_W'(10);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod      = PW'(mul_a) * PW'(mul_b);
  assign div_start = (state_q == S_M3);

  fss_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (prod[DW-1:0]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    state_d  = state_q;
    qpos_d   = qpos_q;
    lmp_d    = lmp_q;
    have_d   = have_q;
    cc_d     = cc_q;
    prev_d   = prev_q;
    date_d   = date_q;
    run_d    = run_q;
    age_d    = age_q;
    last_d   = last_q;
    gap_d    = gap_q;
    r_d      = r_q;
    bit_d    = bit_q;
    sq_d     = sq_q;
    num_d    = num_q;
    score_d  = score_q;
    match_d  = match_q;
    oscore_d = oscore_q;
    omatch_d = omatch_q;
    ovalid_d = (out_o.valid && out_o.ready) ? 1'b0 : ovalid_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          age_d  = in_i.age_seconds;
          last_d = in_i.last;
          gap_d  = cc_q - lmp_q;
          r_d    = '0;
          bit_d  = 4'd15;
          if (date_bad) date_d = 1'b0;
          if (active) begin
            prev_d = in_i.text_char;
            cc_d   = cc_q + CW'(1);
          end
          if (hit) begin
            run_d  = sat_add(run_q, boundary ? DATE_BONUS : ONE_Q16);
            lmp_d  = cc_q;
            have_d = 1'b1;
            qpos_d = qpos_q + 6'd1;
          end
          if (hit && have_q) state_d = S_PSQ;
          else if (in_i.last) state_d = S_FIN;
        end
      end
      S_PSQ: begin
        if (gap_q == CW'(1)) begin
          run_d   = sat_add(run_q, ONE_Q16);
          state_d = last_q ? S_FIN : S_IDLE;
        end else begin
          sq_d    = prod[33:0];
          state_d = S_PMUL;
        end
      end
      S_PMUL: begin
        if (prod <= (PW'(1) << 34)) r_d = cand;
        if (bit_q == 4'd0) begin
          run_d   = sat_add(run_q, (prod <= (PW'(1) << 34)) ? 32'(cand) : 32'(r_q));
          state_d = last_q ? S_FIN : S_IDLE;
        end else begin
          bit_d   = bit_q - 4'd1;
          state_d = S_PSQ;
        end
      end
      S_FIN: begin
        score_d = sfin;
        match_d = 1'b1;
        if (qlen_eff == 6'd0) begin
          state_d = S_AGE;
        end else if (qpos_q < qlen_eff) begin
          score_d = '0;
          match_d = 1'b0;
          state_d = S_OUT;
        end else begin
          state_d = S_M1;
        end
      end
      S_M1: begin
        num_d   = prod[NUM_W-1:0];
        state_d = S_M2;
      end
      S_M2: begin
        num_d   = prod[NUM_W-1:0];
        state_d = S_M3;
      end
      S_M3: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          score_d = (quo[NUM_W-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
          state_d = S_AGE;
        end
      end
      S_AGE: begin
        if (age_q < AGE_HOUR) score_d = sat_add(score_q, BONUS_HOUR);
        else if (age_q < AGE_DAY) score_d = sat_add(score_q, BONUS_DAY);
        else if (age_q < AGE_WEEK) score_d = sat_add(score_q, BONUS_WEEK);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          oscore_d = score_q;
          omatch_d = match_q;
          qpos_d   = '0;
          lmp_d    = '0;
          have_d   = 1'b0;
          cc_d     = '0;
          prev_d   = '0;
          date_d   = 1'b1;
          run_d    = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qchars_q <= '0;
      qlen_q   <= '0;
      state_q  <= S_IDLE;
      qpos_q   <= '0;
      lmp_q    <= '0;
      have_q   <= 1'b0;
      cc_q     <= '0;
      prev_q   <= '0;
      date_q   <= 1'b1;
      run_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_CHARS_LOW:  qchars_q[63:0]    <= cfg_wdata_i;
          REG_CHARS_MID:  qchars_q[127:64]  <= cfg_wdata_i;
          REG_CHARS_HIGH: qchars_q[191:128] <= cfg_wdata_i;
          REG_CHARS_TOP:  qchars_q[255:192] <= cfg_wdata_i;
          REG_QLEN:       qlen_q            <= cfg_wdata_i[5:0];
          default:        qlen_q            <= qlen_q;
        endcase
      end
      state_q  <= state_d;
      qpos_q   <= qpos_d;
      lmp_q    <= lmp_d;
      have_q   <= have_d;
      cc_q     <= cc_d;
      prev_q   <= prev_d;
      date_q   <= date_d;
      run_q    <= run_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    age_q    <= age_d;
    last_q   <= last_d;
    gap_q    <= gap_d;
    r_q      <= r_d;
    bit_q    <= bit_d;
    sq_q     <= sq_d;
    num_q    <= num_d;
    score_q  <= score_d;
    match_q  <= match_d;
    oscore_q <= oscore_d;
    omatch_q <= omatch_d;
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.score       = oscore_q;
  assign out_o.all_matched = omatch_q;

  `FSS_ASSERT_NOW(a_unmatched_zero, out_o.valid && !out_o.all_matched, out_o.score == 32'd0)
  `FSS_ASSERT_NOW(a_qpos_bound, 1'b1, qpos_q <= 6'(MAX_QUERY))
  `FSS_ASSERT_NEXT(a_plain_byte, in_acc && !in_i.last && !(hit && have_q), in_i.ready)
  `FSS_ASSERT_NOW(a_div_only_waiting, div_done, state_q == S_DIV)

endmodule
